>>> sv/utd_pkg.sv
// Shared types, constants and helper functions of the UTF-8 to UTF-16 decoder.
package utd_pkg;

    // Widths fixed by the interface
    localparam int BYTE_W      = 8;
    localparam int UNIT_W      = 31;
    localparam int MAX_UNITS_W = 16;
    localparam int LEN_W       = 3;

    // Default width of the per-string output counter
    localparam int COUNT_WIDTH_DEF = 16;

    // Reset values of the configuration registers
    localparam logic                   UNIT_MODE_RST = 1'b0;
    localparam logic [MAX_UNITS_W-1:0] MAX_UNITS_RST = 16'd1024;

    // Configuration register indexes
    localparam logic CFG_UNIT_MODE = 1'b0;
    localparam logic CFG_MAX_UNITS = 1'b1;

    // Surrogate pair constants
    localparam logic [UNIT_W-1:0] SURR_BASE = 31'h0001_0000;
    localparam logic [15:0]       HI_BASE   = 16'hD800;
    localparam logic [15:0]       LO_BASE   = 16'hDC00;

    // Result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // Status codes of a result
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOLOW   = 2'd3
    } status_t;

    // One result item
    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              has_unit;
        status_t           status;
        logic              final_res;
    } res_t;

    // Up to two results produced by one input byte
    typedef struct packed {
        res_t       r0;
        res_t       r1;
        logic [1:0] n;
    } push_t;

    // Builds a result with the end mark cleared.
    function automatic res_t make_res(input logic [UNIT_W-1:0] u, input logic has,
                                      input status_t st);
        res_t r;
        r.unit      = u;
        r.has_unit  = has;
        r.status    = st;
        r.final_res = 1'b0;
        return r;
    endfunction

    // Sequence length announced by a lead byte; zero for a byte that cannot lead.
    function automatic logic [LEN_W-1:0] lead_len(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] len;
        if (b[7] == 1'b0)
            len = 3'd1;
        else if (b[7:5] == 3'b110)
            len = 3'd2;
        else if (b[7:4] == 4'b1110)
            len = 3'd3;
        else if (b[7:3] == 5'b11110)
            len = 3'd4;
        else if (b[7:2] == 6'b111110)
            len = 3'd5;
        else if (b[7:1] == 7'b1111110)
            len = 3'd6;
        else
            len = 3'd0;
        return len;
    endfunction

    // Payload bits of a lead byte for a sequence of the given length.
    function automatic logic [BYTE_W-1:0] lead_mask(input logic [LEN_W-1:0] len);
        logic [3:0] sh;
        sh = {1'b0, len} + 4'd1;
        return 8'hFF >> sh;
    endfunction

endpackage

>>> sv/utf8_to_utf16_decoder.sv
// UTF-8 byte stream decoder that emits UTF-16 units or whole code points, one result per transfer.
// Each transfer on the input carries one UTF-8 byte and an end-of-string mark. A byte is
// registered on input and decoded in a single pass once the queue has room, giving zero, one or
// two results (a surrogate pair, or a high surrogate followed by a no-room status) that go into
// a four-entry result queue. One byte is accepted every cycle as long as the queue has room for
// two results; the output side delivers one result per cycle while out_stall is low. The first
// result of a byte is offered once it has passed the input register and the result queue.
// Configuration registers are to be written only while no string byte is in flight.
module utf8_to_utf16_decoder #(
    parameter int COUNT_WIDTH = utd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [utd_pkg::BYTE_W-1:0]        data_byte,
    input  logic                              end_of_string,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [utd_pkg::UNIT_W-1:0]        unit,
    output logic                              has_unit,
    output logic [1:0]                        status,
    output logic                              final_res,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [utd_pkg::MAX_UNITS_W-1:0]   cfg_data
);

    logic                              unit_mode_reg;
    logic [utd_pkg::MAX_UNITS_W-1:0]   max_units_reg;
    logic                              in_valid_reg, in_valid_next;
    logic [utd_pkg::BYTE_W-1:0]        byte_reg;
    logic                              eos_reg;
    logic                              room;
    logic                              go;
    logic                              accept;
    utd_pkg::push_t                    push;
    utd_pkg::res_t                     head;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_mode_reg <= utd_pkg::UNIT_MODE_RST;
            max_units_reg <= utd_pkg::MAX_UNITS_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == utd_pkg::CFG_UNIT_MODE)
                unit_mode_reg <= cfg_data[0];
            else if (cfg_index == utd_pkg::CFG_MAX_UNITS)
                max_units_reg <= cfg_data;
        end
    end

    // Input register: a byte is decoded when the queue can take its results.
    assign go       = in_valid_reg && room;
    assign in_stall = in_valid_reg && !room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (go)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= data_byte;
            eos_reg  <= end_of_string;
        end
    end

    // Decoder proper.
    utd_decode #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .go            (go),
        .data_byte     (byte_reg),
        .end_of_string (eos_reg),
        .unit_mode     (unit_mode_reg),
        .max_units     (max_units_reg),
        .push          (push)
    );

    // Result queue.
    utd_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    // Output payload from the head of the queue.
    assign unit      = head.unit;
    assign has_unit  = head.has_unit;
    assign status    = head.status;
    assign final_res = head.final_res;

endmodule

>>> sv/utd_decode.sv
// Decoder state and the single-pass decode of one registered UTF-8 byte.
module utd_decode #(
    parameter int COUNT_WIDTH = utd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               go,
    input  logic [utd_pkg::BYTE_W-1:0]         data_byte,
    input  logic                               end_of_string,
    input  logic                               unit_mode,
    input  logic [utd_pkg::MAX_UNITS_W-1:0]    max_units,
    output utd_pkg::push_t                     push
);

    localparam int CMP_W = (COUNT_WIDTH > utd_pkg::MAX_UNITS_W) ? COUNT_WIDTH
                                                                : utd_pkg::MAX_UNITS_W;

    logic [utd_pkg::UNIT_W-1:0] acc_reg, acc_next;
    logic [utd_pkg::LEN_W-1:0]  rem_reg, rem_next;
    logic [COUNT_WIDTH-1:0]     cnt_reg, cnt_next;
    utd_pkg::status_t           outc_reg, outc_next;
    logic                       disc_reg, disc_next;

    logic [utd_pkg::LEN_W-1:0]  len;
    logic [utd_pkg::UNIT_W-1:0] cp_cont;
    logic [utd_pkg::UNIT_W-1:0] emit_cp;
    logic [utd_pkg::UNIT_W-1:0] v;
    logic [15:0]                hi;
    logic [15:0]                lo;
    logic                       emit_req;
    logic                       full;
    logic [COUNT_WIDTH-1:0]     cnt1;
    logic [COUNT_WIDTH-1:0]     cnt2;
    utd_pkg::push_t             p;

    // Saturating increment of the output counter.
    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        return (c == '1) ? c : c + COUNT_WIDTH'(1);
    endfunction

    // Values that do not depend on the decode branch.
    assign len     = utd_pkg::lead_len(data_byte);
    assign cp_cont = {acc_reg[utd_pkg::UNIT_W-7:0], data_byte[5:0]};
    assign cnt1    = sat_inc(cnt_reg);
    assign cnt2    = sat_inc(cnt1);
    assign full    = CMP_W'(cnt_reg) >= CMP_W'(max_units);

    // Decode of one byte: results to push and the next string state.
    always_comb
    begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        outc_next = outc_reg;
        disc_next = disc_reg;
        emit_req  = 1'b0;
        emit_cp   = '0;
        v         = '0;
        hi        = '0;
        lo        = '0;
        p         = '0;
        if (go)
        begin
            if (disc_reg)
            begin
                // Dropping the rest of a failed string; only its end mark reports.
                if (end_of_string)
                begin
                    p.r0 = utd_pkg::make_res('0, 1'b0, outc_reg);
                    p.n  = 2'd1;
                end
            end
            else if (rem_reg == '0)
            begin
                // A lead byte is expected.
                if (full)
                begin
                    p.r0      = utd_pkg::make_res('0, 1'b0, utd_pkg::ST_FULL);
                    p.n       = 2'd1;
                    outc_next = utd_pkg::ST_FULL;
                    disc_next = 1'b1;
                end
                else if (len == 3'd0)
                begin
                    p.r0      = utd_pkg::make_res('0, 1'b0, utd_pkg::ST_INVALID);
                    p.n       = 2'd1;
                    outc_next = utd_pkg::ST_INVALID;
                    disc_next = 1'b1;
                end
                else if (len == 3'd1)
                begin
                    emit_req = 1'b1;
                    emit_cp  = utd_pkg::UNIT_W'(data_byte);
                end
                else
                begin
                    acc_next = utd_pkg::UNIT_W'(data_byte & utd_pkg::lead_mask(len));
                    rem_next = len - 3'd1;
                end
            end
            else
            begin
                // A continuation byte is expected.
                if (data_byte[7:6] != 2'b10)
                begin
                    p.r0      = utd_pkg::make_res('0, 1'b0, utd_pkg::ST_INVALID);
                    p.n       = 2'd1;
                    outc_next = utd_pkg::ST_INVALID;
                    disc_next = 1'b1;
                end
                else
                begin
                    acc_next = cp_cont;
                    rem_next = rem_reg - 3'd1;
                    if (rem_reg == 3'd1)
                    begin
                        emit_req = 1'b1;
                        emit_cp  = cp_cont;
                    end
                end
            end

            // Emit a finished code point as one unit, as a surrogate pair, or as a high surrogate and a no-room status.
            if (emit_req)
            begin
                if (unit_mode || (emit_cp < utd_pkg::SURR_BASE))
                begin
                    p.r0     = utd_pkg::make_res(emit_cp, 1'b1, utd_pkg::ST_OK);
                    p.n      = 2'd1;
                    cnt_next = cnt1;
                end
                else
                begin
                    v    = emit_cp - utd_pkg::SURR_BASE;
                    hi   = utd_pkg::HI_BASE + v[25:10];
                    lo   = utd_pkg::LO_BASE | {6'd0, v[9:0]};
                    p.r0 = utd_pkg::make_res(utd_pkg::UNIT_W'(hi), 1'b1, utd_pkg::ST_OK);
                    p.n  = 2'd2;
                    if (CMP_W'(cnt1) < CMP_W'(max_units))
                    begin
                        p.r1     = utd_pkg::make_res(utd_pkg::UNIT_W'(lo), 1'b1,
                                                     utd_pkg::ST_OK);
                        cnt_next = cnt2;
                    end
                    else
                    begin
                        p.r1      = utd_pkg::make_res('0, 1'b0, utd_pkg::ST_NOLOW);
                        cnt_next  = cnt1;
                        outc_next = utd_pkg::ST_NOLOW;
                        disc_next = 1'b1;
                    end
                end
            end

            // End of string: report a cut-off sequence, mark the last result, clear.
            if (end_of_string)
            begin
                if (!disc_next && (rem_next != '0))
                begin
                    p.r0 = utd_pkg::make_res('0, 1'b0, utd_pkg::ST_INVALID);
                    p.n  = 2'd1;
                end
                if (p.n == 2'd2)
                    p.r1.final_res = 1'b1;
                else if (p.n == 2'd1)
                    p.r0.final_res = 1'b1;
                acc_next  = '0;
                rem_next  = '0;
                cnt_next  = '0;
                outc_next = utd_pkg::ST_OK;
                disc_next = 1'b0;
            end
        end
    end

    assign push = p;

    // String state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            outc_reg <= utd_pkg::ST_OK;
            disc_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_next;
            outc_reg <= outc_next;
            disc_reg <= disc_next;
        end
    end

endmodule

>>> sv/utd_res_fifo.sv
// Small result queue that takes up to two results a cycle and hands out one when not stalled.
module utd_res_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  utd_pkg::push_t push,
    output logic           room,
    output logic           out_valid,
    input  logic           out_stall,
    output utd_pkg::res_t  head
);

    utd_pkg::res_t                   mem [utd_pkg::FIFO_DEPTH];
    logic [utd_pkg::FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [utd_pkg::FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [utd_pkg::FIFO_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [utd_pkg::FIFO_PTR_W-1:0]  wr_ptr_p1;
    logic                            pop;

    // Transfer out of the queue and space for a worst-case push of two.
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign room      = (cnt_reg <= utd_pkg::FIFO_CNT_W'(utd_pkg::FIFO_DEPTH - 2));
    assign head      = mem[rd_ptr_reg];
    assign wr_ptr_p1 = wr_ptr_reg + utd_pkg::FIFO_PTR_W'(1);

    // Pointer and fill level arithmetic.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + utd_pkg::FIFO_PTR_W'(push.n);
        rd_ptr_next = pop ? rd_ptr_reg + utd_pkg::FIFO_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + utd_pkg::FIFO_CNT_W'(push.n)
                      - utd_pkg::FIFO_CNT_W'(pop);
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            mem[wr_ptr_reg] <= push.r0;
        if (push.n == 2'd2)
            mem[wr_ptr_p1] <= push.r1;
    end

    // Queue control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
